/* sv/compact_hilbert_index_encode_core_macros.svh */
// Assertion macros for the compact Hilbert index encoder checker.
// Depends on nothing; included by the checker file.
`ifndef COMPACT_HILBERT_INDEX_ENCODE_CORE_MACROS_SVH
`define COMPACT_HILBERT_INDEX_ENCODE_CORE_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define CHIE_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Clocked assertion that is also checked during reset.
`define CHIE_ASSERT_RST(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

/* sv/chie_pkg.sv */
// Shared constants, types and level-step functions for the compact Hilbert
// index encoder. No dependencies.
package chie_pkg;

	localparam int MAX_AXES    = 4;
	localparam int NUM_REGS    = 4;
	localparam int MAX_LEVELS  = 16;
	localparam int INDEX_WIDTH = 64;
	localparam int COORD_W     = 16;
	localparam int BITS_W      = 5;
	localparam int NAXES_W     = 3;
	localparam int CFG_ADDR_W  = 3;
	localparam int CFG_DATA_W  = BITS_W;
	localparam int DIG_W       = NUM_REGS;
	localparam int CNT_W       = $clog2(NUM_REGS + 1);
	localparam int POS_W       = $clog2(NUM_REGS);
	localparam int SUM_W       = BITS_W + POS_W;

	localparam logic [NAXES_W-1:0] RESET_NUM_AXES  = NAXES_W'(2);
	localparam logic [BITS_W-1:0]  RESET_AXIS_BITS = BITS_W'(8);

	typedef logic [COORD_W-1:0]     coord_t;
	typedef logic [DIG_W-1:0]       digit_t;
	typedef logic [CNT_W-1:0]       cnt_t;
	typedef logic [POS_W-1:0]       pos_t;
	typedef logic [BITS_W-1:0]      bits_t;
	typedef logic [INDEX_WIDTH-1:0] index_t;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_NUM_AXES    = 3'd0,
		REG_AXIS_BITS_0 = 3'd1,
		REG_AXIS_BITS_1 = 3'd2,
		REG_AXIS_BITS_2 = 3'd3,
		REG_AXIS_BITS_3 = 3'd4
	} cfg_reg_t;

	// Running state of the curve walk as it moves down the levels.
	typedef struct packed {
		digit_t ent;
		pos_t   dir;
		index_t h;
	} walk_t;

	function automatic digit_t low_mask(cnt_t k);
		digit_t m;
		m = '0;
		for (int b = 0; b < DIG_W; b++) begin
			if (b < k) m[b] = 1'b1;
		end
		return m;
	endfunction

	// Rotate the low k bits right by r, with r below k.
	function automatic digit_t rot_right(digit_t x, pos_t r, cnt_t k);
		digit_t y;
		cnt_t   src;
		y = '0;
		for (int b = 0; b < DIG_W; b++) begin
			src = cnt_t'(b) + cnt_t'(r);
			if (src >= k) src = src - k;
			if (b < k) y[b] = x[src[POS_W-1:0]];
		end
		return y;
	endfunction

	function automatic digit_t rot_left(digit_t x, pos_t r, cnt_t k);
		digit_t y;
		cnt_t   src;
		y = '0;
		for (int b = 0; b < DIG_W; b++) begin
			src = cnt_t'(b) + k - cnt_t'(r);
			if (src >= k) src = src - k;
			if (b < k) y[b] = x[src[POS_W-1:0]];
		end
		return y;
	endfunction

	function automatic digit_t gray_inv(digit_t g);
		digit_t v;
		v = '0;
		v[DIG_W-1] = g[DIG_W-1];
		for (int b = DIG_W - 2; b >= 0; b--) begin
			v[b] = v[b+1] ^ g[b];
		end
		return v;
	endfunction

	function automatic digit_t entry_of(digit_t w);
		digit_t t;
		t = (w - digit_t'(1)) & ~digit_t'(1);
		if (w == '0) t = '0;
		return t ^ (t >> 1);
	endfunction

	// Count of trailing ones never exceeds k here, so the wrap is one compare.
	function automatic pos_t dir_of(digit_t w, cnt_t k);
		digit_t v;
		cnt_t   c;
		logic   run;
		v   = w[0] ? w : (w - digit_t'(1));
		c   = '0;
		run = 1'b1;
		for (int b = 0; b < DIG_W; b++) begin
			if (run && v[b]) c = c + cnt_t'(1);
			else run = 1'b0;
		end
		if (c >= k || w == '0) c = '0;
		return c[POS_W-1:0];
	endfunction

	// One level of the walk; a level with no active axes leaves it as it is.
	function automatic walk_t level_step(walk_t cur, digit_t plane, cnt_t k);
		walk_t  o;
		digit_t e;
		digit_t w;
		cnt_t   r;
		cnt_t   nd;
		o  = cur;
		e  = cur.ent & low_mask(k);
		r  = cnt_t'(cur.dir) + cnt_t'(1);
		if (r == k) r = '0;
		w  = gray_inv(rot_right(plane ^ e, r[POS_W-1:0], k));
		nd = cnt_t'(cur.dir) + cnt_t'(dir_of(w, k)) + cnt_t'(1);
		if (nd >= k) nd = nd - k;
		if (k != '0) begin
			o.h   = (cur.h << k) | index_t'(w);
			o.ent = e ^ rot_left(entry_of(w), r[POS_W-1:0], k);
			o.dir = nd[POS_W-1:0];
		end
		return o;
	endfunction

endpackage

/* sv/compact_hilbert_index_encode_core.sv */
// Compact Hilbert index encoder: configuration registers and a pipeline
// with one stage per level. Depends on chie_pkg.
//
// Usage: software writes num_axes (index 0) and axis_bits_0..3 (indexes 1..4)
// through cfg_we/cfg_addr/cfg_wdata while no item is in flight. Points enter
// on the in_valid/in_ready channel as coord_0..coord_3; each gives one
// curve_index on the out_valid/out_ready channel, in order.
// There is one pipeline stage per level, MAX_LEVELS (16) in all, each doing
// one level's rotate, Gray decode and entry/direction update. One item can be
// taken every cycle while the output is not stalled.
// Levels above the largest bit count pass the item through unchanged.
// Unsupported configurations (no axes or more than four, a bit count above 16,
// bit counts summing above 64, all counts zero) give an index of zero.
// When out_ready is low while a result is shown, the whole pipeline holds and
// in_ready drops; nothing is lost or repeated. Reset empties the pipeline and
// loads num_axes = 2 and every axis bit count = 8.
module compact_hilbert_index_encode_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [chie_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [chie_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  chie_pkg::coord_t                coord_0,
	input  chie_pkg::coord_t                coord_1,
	input  chie_pkg::coord_t                coord_2,
	input  chie_pkg::coord_t                coord_3,
	output logic                            out_valid,
	input  logic                            out_ready,
	output chie_pkg::index_t                curve_index
);
	import chie_pkg::*;

	logic [NAXES_W-1:0]    num_axes_q;
	bits_t                 axis_bits_q [NUM_REGS];
	logic [CFG_ADDR_W-1:0] cfg_off;

	logic                  used [NUM_REGS];
	pos_t                  pos [NUM_REGS];
	logic                  bad;
	logic [SUM_W-1:0]      total;
	bits_t                 top;
	logic                  over;

	coord_t                coord_in [NUM_REGS];
	logic                  adv;

	logic                  vld_s [1:MAX_LEVELS];
	walk_t                 walk_s [1:MAX_LEVELS];
	coord_t                coord_s [1:MAX_LEVELS-1][NUM_REGS];

	logic                  st_vld [MAX_LEVELS];
	walk_t                 st_walk [MAX_LEVELS];
	coord_t                st_coord [MAX_LEVELS][NUM_REGS];

	assign cfg_off = cfg_addr - CFG_ADDR_W'(REG_AXIS_BITS_0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_axes_q <= RESET_NUM_AXES;
			for (int i = 0; i < NUM_REGS; i++) axis_bits_q[i] <= RESET_AXIS_BITS;
		end else if (cfg_we) begin
			if (cfg_addr == REG_NUM_AXES) begin
				num_axes_q <= cfg_wdata[NAXES_W-1:0];
			end else if (cfg_addr >= REG_AXIS_BITS_0 && cfg_addr <= REG_AXIS_BITS_3) begin
				axis_bits_q[cfg_off[POS_W-1:0]] <= cfg_wdata;
			end
		end
	end

	// Axis ranks by (bit count, axis number), and the unsupported cases.
	always_comb begin
		total = '0;
		top   = '0;
		over  = 1'b0;
		for (int i = 0; i < NUM_REGS; i++) begin
			used[i] = (i < num_axes_q);
			pos[i]  = '0;
		end
		for (int i = 0; i < NUM_REGS; i++) begin
			if (used[i]) begin
				total = total + SUM_W'(axis_bits_q[i]);
				if (axis_bits_q[i] > top) top = axis_bits_q[i];
				if (axis_bits_q[i] > BITS_W'(MAX_LEVELS)) over = 1'b1;
			end
			for (int a = 0; a < NUM_REGS; a++) begin
				if (used[a] && a != i &&
				    (axis_bits_q[a] < axis_bits_q[i] ||
				     (axis_bits_q[a] == axis_bits_q[i] && a < i))) begin
					pos[i] = pos[i] + pos_t'(1);
				end
			end
		end
		bad = (num_axes_q == '0) || (num_axes_q > NAXES_W'(MAX_AXES)) || over ||
		      (total > SUM_W'(INDEX_WIDTH)) || (top == '0);
	end

	assign coord_in[0] = coord_0;
	assign coord_in[1] = coord_1;
	assign coord_in[2] = coord_2;
	assign coord_in[3] = coord_3;

	// The whole pipeline moves together; it holds only while a result waits.
	assign adv      = !vld_s[MAX_LEVELS] || out_ready;
	assign in_ready = adv;

	for (genvar g = 0; g < MAX_LEVELS; g++) begin : g_level
		localparam int L = MAX_LEVELS - g;

		digit_t plane;
		cnt_t   k;
		cnt_t   first;
		pos_t   lr;

		if (g == 0) begin : g_head
			assign st_vld[g]   = in_valid;
			assign st_walk[g]  = '0;
			assign st_coord[g] = coord_in;
		end else begin : g_body
			assign st_vld[g]   = vld_s[g];
			assign st_walk[g]  = walk_s[g];
			assign st_coord[g] = coord_s[g];
		end

		// Active axes at this level fill the plane in rank order.
		always_comb begin
			k     = '0;
			first = '0;
			plane = '0;
			lr    = '0;
			for (int i = 0; i < NUM_REGS; i++) begin
				if (used[i] && axis_bits_q[i] >= BITS_W'(L)) k = k + cnt_t'(1);
				else if (used[i]) first = first + cnt_t'(1);
			end
			for (int i = 0; i < NUM_REGS; i++) begin
				if (used[i] && axis_bits_q[i] >= BITS_W'(L)) begin
					lr        = pos_t'(cnt_t'(pos[i]) - first);
					plane[lr] = st_coord[g][i][L-1];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[g+1] <= 1'b0;
			else if (adv) vld_s[g+1] <= st_vld[g];
		end

		always_ff @(posedge clk) begin
			if (adv) walk_s[g+1] <= level_step(st_walk[g], plane, k);
		end

		if (g < MAX_LEVELS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (adv) coord_s[g+1] <= st_coord[g];
			end
		end
	end

	assign out_valid   = vld_s[MAX_LEVELS];
	assign curve_index = bad ? '0 : walk_s[MAX_LEVELS].h;

endmodule

/* sv/chie_checker.sv */
// Port-level checker for the compact Hilbert index encoder, bound to the top.
// Depends on chie_pkg and the assertion macro header.
`include "compact_hilbert_index_encode_core_macros.svh"

module chie_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input chie_pkg::index_t curve_index
);

	// A result that is not taken stays on the port unchanged.
	`CHIE_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(curve_index), "stalled item changed or dropped")

	// The pipeline takes an item exactly when its last stage can move.
	`CHIE_ASSERT(a_in_ready, clk, arst_n, in_ready == (!out_valid || out_ready), "input ready does not follow output stall")

	// An item offered while the output stage is empty is taken at once.
	`CHIE_ASSERT(a_flow, clk, arst_n, in_valid && !out_valid |-> in_ready, "pipeline stalled without a waiting item")

	// A cycle spent in reset leaves the pipeline empty.
	`CHIE_ASSERT_RST(a_reset, clk, !arst_n |=> !out_valid, "result shown during reset")

endmodule

bind compact_hilbert_index_encode_core chie_checker u_chie_checker (.*);

/* test/compact_hilbert_index_encode_core_tb.sv */
// Testbench for compact_hilbert_index_encode_core: drives points and register writes,
// predicts each compact Hilbert index in a scoreboard and compares the results in order.
// Depends on chie_pkg and the encoder core.
module compact_hilbert_index_encode_core_tb;
	import chie_pkg::*;

	localparam int PERIOD        = 12;
	localparam int PIPE_DRAIN    = 24;
	localparam int RANDOM_PHASES = 17;
	localparam int PHASE_POINTS  = 100;
	localparam int REPORT_LIMIT  = 10;
	localparam logic [CFG_ADDR_W-1:0] REG_BEYOND_LIST = CFG_ADDR_W'(5);

	typedef logic [NUM_REGS-1:0][COORD_W-1:0] point_t;

	class hilbert_scoreboard;
		logic [NAXES_W-1:0] num_axes_q;
		bits_t              axis_bits_q[NUM_REGS];
		index_t             expected_q[$];
		int unsigned        errors;

		function new();
			num_axes_q = RESET_NUM_AXES;
			foreach (axis_bits_q[i]) axis_bits_q[i] = RESET_AXIS_BITS;
			errors = 0;
		endfunction

		function void write_register(logic [CFG_ADDR_W-1:0] addr,
			logic [CFG_DATA_W-1:0] data);
			case (addr)
				REG_NUM_AXES:    num_axes_q = data[NAXES_W-1:0];
				REG_AXIS_BITS_0: axis_bits_q[0] = data;
				REG_AXIS_BITS_1: axis_bits_q[1] = data;
				REG_AXIS_BITS_2: axis_bits_q[2] = data;
				REG_AXIS_BITS_3: axis_bits_q[3] = data;
				default: ;
			endcase
		endfunction

		function index_t curve_index_of(point_t pt);
			int unsigned n, top, total, first, k, mask, plane, x, w, r, t, v, run, j;
			int unsigned ent, dir;
			int unsigned order[NUM_REGS];
			index_t h;
			n = num_axes_q;
			top = 0;
			total = 0;
			ent = 0;
			dir = 0;
			h = '0;
			if (n == 0 || n > MAX_AXES || n > NUM_REGS) return '0;
			for (int i = 0; i < n; i++) begin
				if (axis_bits_q[i] > MAX_LEVELS) return '0;
				if (axis_bits_q[i] > top) top = axis_bits_q[i];
				total += axis_bits_q[i];
			end
			if (total > INDEX_WIDTH || top == 0) return '0;

			// Stable sort of the axes by bit count, so ties keep axis order.
			for (int i = 0; i < n; i++) begin
				j = i;
				while (j > 0 && axis_bits_q[order[j-1]] > axis_bits_q[i]) begin
					order[j] = order[j-1];
					j--;
				end
				order[j] = i;
			end

			for (int s = top; s >= 1; s--) begin
				first = 0;
				while (first < n && axis_bits_q[order[first]] < s) first++;
				k = n - first;
				mask = (1 << k) - 1;
				ent &= mask;
				dir %= k;
				plane = 0;
				for (j = 0; j < k; j++) plane |= int'(pt[order[first + j]][s - 1]) << j;
				r = (dir + 1) % k;
				x = plane ^ ent;
				x = ((x >> r) | (x << (k - r))) & mask;
				w = 0;
				while (x != 0) begin
					w ^= x;
					x >>= 1;
				end
				h = (h << k) | index_t'(w);
				t = 0;
				run = 0;
				if (w != 0) begin
					t = 2 * ((w - 1) / 2);
					t = t ^ (t >> 1);
					v = w[0] ? w : w - 1;
					while (v[0]) begin
						run++;
						v >>= 1;
					end
				end
				ent ^= ((t << r) | (t >> (k - r))) & mask;
				dir = (dir + run % k + 1) % k;
			end
			return h;
		endfunction

		function void note_point(point_t pt);
			expected_q.push_back(curve_index_of(pt));
		endfunction

		function void check_index(index_t got);
			index_t want;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("unexpected curve_index %h with no point pending", got);
				return;
			end
			want = expected_q.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("curve_index mismatch: expected %h, got %h", want, got);
			end
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	coord_t                coord_0   = '0;
	coord_t                coord_1   = '0;
	coord_t                coord_2   = '0;
	coord_t                coord_3   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	index_t                curve_index;

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;

	hilbert_scoreboard sb = new();

	compact_hilbert_index_encode_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.coord_0    (coord_0),
		.coord_1    (coord_1),
		.coord_2    (coord_2),
		.coord_3    (coord_3),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.curve_index(curve_index)
	);

	always #(PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_point({coord_3, coord_2, coord_1, coord_0});
		if (arst_n && out_valid && out_ready)
			sb.check_index(curve_index);
	end

	task automatic set_idle(int unsigned profile);
		case (profile % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
			default: begin send_idle_pct = 30; recv_stall_pct = 30; end
		endcase
	endtask

	// Valid stays high between back-to-back items; it only drops for a gap.
	task automatic send_point(point_t pt);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		{coord_3, coord_2, coord_1, coord_0} <= pt;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_coords(coord_t c0, coord_t c1, coord_t c2, coord_t c3);
		send_point({c3, c2, c1, c0});
	endtask

	task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= data;
		sb.write_register(addr, data);
		@(posedge clk);
	endtask

	// Every setting ends with a write to an unmapped index, which must change nothing.
	task automatic configure(logic [CFG_DATA_W-1:0] n_data, bits_t b0, bits_t b1,
		bits_t b2, bits_t b3);
		write_reg(REG_NUM_AXES, n_data);
		write_reg(REG_AXIS_BITS_0, b0);
		write_reg(REG_AXIS_BITS_1, b1);
		write_reg(REG_AXIS_BITS_2, b2);
		write_reg(REG_AXIS_BITS_3, b3);
		write_reg(REG_BEYOND_LIST + CFG_ADDR_W'($urandom_range(2)),
			CFG_DATA_W'($urandom_range(31)));
		cfg_we <= 1'b0;
	endtask

	task automatic configure_random();
		logic [CFG_DATA_W-1:0] n_data;
		bits_t                 b[NUM_REGS];
		n_data = CFG_DATA_W'($urandom_range(1, 4));
		if ($urandom_range(3) == 0) n_data[CFG_DATA_W-1:NAXES_W] = 2'($urandom_range(3));
		if ($urandom_range(11) == 0) n_data = CFG_DATA_W'($urandom_range(31));
		foreach (b[i]) begin
			b[i] = BITS_W'($urandom_range(16));
			if ($urandom_range(19) == 0) b[i] = BITS_W'($urandom_range(17, 31));
		end
		configure(n_data, b[0], b[1], b[2], b[3]);
	endtask

	// Lets the pipeline empty before the registers are touched again.
	// The first edge lets the monitor note the last accepted item.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (PIPE_DRAIN) @(posedge clk);
	endtask

	function automatic point_t random_point();
		point_t pt;
		for (int i = 0; i < NUM_REGS; i++) begin
			case ($urandom_range(7))
				0: pt[i] = '0;
				1: pt[i] = '1;
				default: pt[i] = COORD_W'($urandom_range(65535));
			endcase
		end
		return pt;
	endfunction

	initial begin
		#(PERIOD * 400000);
		$display("Mismatches found");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, first under the reset setting of two axes of eight bits.
		set_idle(3);
		send_coords(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_coords(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_coords(16'h5555, 16'hAAAA, 16'h1234, 16'h4321);
		send_coords(16'h00FF, 16'hFF00, 16'h0000, 16'hFFFF);
		send_coords(16'h0080, 16'h0001, 16'hFFFF, 16'h0000);
		settle();
		configure(5'd4, 5'd16, 5'd16, 5'd16, 5'd16);
		send_coords(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_coords(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_coords(16'h8001, 16'h7FFE, 16'hA5A5, 16'h5A5A);
		settle();
		configure(5'd1, 5'd16, 5'd31, 5'd31, 5'd31);
		send_coords(16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
		send_coords(16'h1234, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		settle();
		configure(5'd3, 5'd3, 5'd0, 5'd16, 5'd31);
		send_coords(16'hFFFF, 16'hFFFF, 16'hC3C3, 16'hFFFF);
		send_coords(16'h0005, 16'h0000, 16'h8000, 16'h0000);
		settle();
		// Equal bit counts on three axes exercise the tie order.
		configure(5'd4, 5'd5, 5'd5, 5'd2, 5'd5);
		send_coords(16'h0015, 16'h000A, 16'h0003, 16'h001F);
		send_coords(16'h000B, 16'h001C, 16'h0001, 16'h0006);
		settle();
		// Every bit count zero gives an index of zero.
		configure(5'd4, 5'd0, 5'd0, 5'd0, 5'd0);
		send_coords(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		settle();
		configure(5'd0, 5'd8, 5'd8, 5'd8, 5'd8);
		send_coords(16'hFFFF, 16'h1234, 16'h5678, 16'h9ABC);
		settle();
		configure(5'b11111, 5'd8, 5'd8, 5'd8, 5'd8);
		send_coords(16'hFFFF, 16'h1234, 16'h5678, 16'h9ABC);
		settle();
		configure(5'd2, 5'd17, 5'd4, 5'd0, 5'd0);
		send_coords(16'hFFFF, 16'h000F, 16'h0000, 16'h0000);
		settle();
		configure(5'd4, 5'd4, 5'd4, 5'd4, 5'd31);
		send_coords(16'h000F, 16'h0003, 16'h000C, 16'hFFFF);
		settle();
		configure(5'b01001, 5'd1, 5'd0, 5'd0, 5'd0);
		send_coords(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_coords(16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
		settle();

		// Random part: one setting and one idling profile per phase.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: configure(5'd4, 5'd16, 5'd16, 5'd16, 5'd16);
				1: configure(5'd1, 5'd1, 5'd16, 5'd0, 5'd31);
				2: configure(5'd4, 5'd16, 5'd1, 5'd0, 5'd9);
				default: configure_random();
			endcase
			set_idle(p);
			for (int i = 0; i < PHASE_POINTS; i++) send_point(random_point());
			settle();
		end

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

/* files.f */
+incdir+sv
sv/chie_pkg.sv
sv/compact_hilbert_index_encode_core.sv
sv/chie_checker.sv
test/compact_hilbert_index_encode_core_tb.sv
